/* rtl/dual_pi_speed_controller_defines.svh */
// assertion macros for the dual pi speed controller
// expects clk and arst_n in the scope of use, no other dependencies
`ifndef DUAL_PI_SPEED_CONTROLLER_DEFINES_SVH
`define DUAL_PI_SPEED_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DPSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define DPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dpsc_pkg.sv */
// shared types, constants and register codes of the dual pi speed controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dpsc_pkg;

	// integral width default and fixed-point layout
	localparam int INTEGRAL_BITS_DEF = 32;
	localparam int FRAC_SHIFT        = 20;
	localparam int RPM_W             = 17;
	localparam int ERR_W             = 18;
	localparam int PWM_W             = 8;
	localparam int GAIN_W            = 16;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 16;

	// speed request codes
	typedef enum logic [1:0] {
		CMD_STOP   = 2'd0,
		CMD_SLOW   = 2'd1,
		CMD_FAST   = 2'd2,
		CMD_IGNORE = 2'd3
	} cmd_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SLOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FAST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPAN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR = 3'd5;

	// register reset values
	localparam logic [15:0] PROP_GAIN_RST   = 16'd256;
	localparam logic [15:0] INTEG_GAIN_RST  = 16'd655;
	localparam logic [15:0] TARGET_SLOW_RST = 16'd480;
	localparam logic [15:0] TARGET_FAST_RST = 16'd960;
	localparam logic [7:0]  DRIVE_SPAN_RST  = 8'd50;
	localparam logic [7:0]  DRIVE_FLOOR_RST = 8'd50;

	// configuration seen by the datapath
	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [15:0] target_slow;
		logic [15:0] target_fast;
		logic [7:0]  drive_span;
		logic [7:0]  drive_floor;
	} cfg_t;

	// pipeline load controls from the top to each side
	typedef struct packed {
		logic ld_s2;
		logic upd_integ;
		logic ld_s3;
	} pipe_ctrl_t;

endpackage

`default_nettype wire

/* rtl/dpsc_in_if.sv */
// input channel: speed request and the two measured speeds
// depends on dpsc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dpsc_in_if
	import dpsc_pkg::*;
();
	logic                    valid;
	logic                    ready;
	cmd_t                    cmd;
	logic signed [RPM_W-1:0] rpm_left;
	logic signed [RPM_W-1:0] rpm_right;

	modport source (output valid, cmd, rpm_left, rpm_right, input ready);
	modport sink   (input valid, cmd, rpm_left, rpm_right, output ready);
endinterface

`default_nettype wire

/* rtl/dpsc_out_if.sv */
// output channel: the two pwm commands
// depends on dpsc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dpsc_out_if
	import dpsc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PWM_W-1:0] pwm_left;
	logic [PWM_W-1:0] pwm_right;

	modport source (output valid, pwm_left, pwm_right, input ready);
	modport sink   (input valid, pwm_left, pwm_right, output ready);
endinterface

`default_nettype wire

/* rtl/dpsc_cfg_regs.sv */
// configuration register file, write only
// depends on dpsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpsc_cfg_regs
	import dpsc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= PROP_GAIN_RST;
			cfg_q.integ_gain  <= INTEG_GAIN_RST;
			cfg_q.target_slow <= TARGET_SLOW_RST;
			cfg_q.target_fast <= TARGET_FAST_RST;
			cfg_q.drive_span  <= DRIVE_SPAN_RST;
			cfg_q.drive_floor <= DRIVE_FLOOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_wdata;
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_wdata;
				REG_TARGET_SLOW: cfg_q.target_slow <= cfg_wdata;
				REG_TARGET_FAST: cfg_q.target_fast <= cfg_wdata;
				REG_DRIVE_SPAN:  cfg_q.drive_span  <= cfg_wdata[7:0];
				REG_DRIVE_FLOOR: cfg_q.drive_floor <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/dpsc_pi_side.sv */
// one pi loop: integral update, gain products, clamp and floor
// depends on dpsc_pkg, driven by the pipeline control of the top level
`timescale 1ns / 1ps
`default_nettype none

module dpsc_pi_side
	import dpsc_pkg::*;
#(
	parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  pipe_ctrl_t                   ctrl,
	input  cfg_t                         cfg,
	input  wire logic [15:0]             target_s1,
	input  wire logic signed [RPM_W-1:0] rpm_s1,
	output logic [PWM_W-1:0]             pwm
);

	localparam int IB     = INTEGRAL_BITS;
	localparam int PPROD_W = GAIN_W + 1 + ERR_W;
	localparam int PTERM_W = PPROD_W + 8;
	localparam int IPROD_W = GAIN_W + 1 + IB;
	localparam int SUM_W   = ((IPROD_W > PTERM_W) ? IPROD_W : PTERM_W) + 1;

	logic signed [IB-1:0]      integral_q;
	logic signed [ERR_W-1:0]   err;
	logic signed [IB:0]        acc_wide;
	logic signed [IB-1:0]      acc;
	logic signed [ERR_W-1:0]   err_s2;
	logic signed [IB-1:0]      acc_s2;
	logic signed [PPROD_W-1:0] pterm_s3;
	logic signed [IPROD_W-1:0] iterm_s3;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   span_lim;
	logic [PWM_W-1:0]          whole;
	logic [PWM_W:0]            pwm_wide;

	// error and saturating integral
	always_comb begin
		err      = $signed({2'b00, target_s1}) - ERR_W'(rpm_s1);
		acc_wide = (IB + 1)'(integral_q) + (IB + 1)'(err);
		if (acc_wide[IB] != acc_wide[IB-1])
			acc = acc_wide[IB] ? {1'b1, {(IB - 1){1'b0}}} : {1'b0, {(IB - 1){1'b1}}};
		else
			acc = acc_wide[IB-1:0];
	end

	// integral state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
		end else if (ctrl.upd_integ) begin
			integral_q <= acc;
		end
	end

	// stage 2: error and new integral
	always_ff @(posedge clk) begin
		if (ctrl.ld_s2) begin
			err_s2 <= err;
			acc_s2 <= acc;
		end
	end

	// stage 3: gain products
	always_ff @(posedge clk) begin
		if (ctrl.ld_s3) begin
			pterm_s3 <= $signed({1'b0, cfg.prop_gain}) * err_s2;
			iterm_s3 <= $signed({1'b0, cfg.integ_gain}) * acc_s2;
		end
	end

	// pi sum in q.20, clamp to 0..span, add floor, saturate the byte
	always_comb begin
		sum      = (SUM_W'(pterm_s3) <<< 8) + SUM_W'(iterm_s3);
		span_lim = $signed(SUM_W'({cfg.drive_span, {FRAC_SHIFT{1'b0}}}));
		if (sum[SUM_W-1] || (sum == '0))
			whole = '0;
		else if (sum >= span_lim)
			whole = cfg.drive_span;
		else
			whole = sum[FRAC_SHIFT +: PWM_W];
		pwm_wide = {1'b0, whole} + {1'b0, cfg.drive_floor};
		pwm      = pwm_wide[PWM_W] ? {PWM_W{1'b1}} : pwm_wide[PWM_W-1:0];
	end

endmodule

`default_nettype wire

/* rtl/dual_pi_speed_controller.sv */
// Dual PI speed controller for the left and right rear motors.
// req channel: one beat carries cmd (0 stop, 1 slow, 2 fast, 3 ignored) and
// the measured speeds rpm_left / rpm_right, signed Q.4 RPM.
// rsp channel: one beat carries pwm_left / pwm_right for each request that
// is not ignored; an ignored request leaves the integrals alone and yields
// no beat.
// Configuration: cfg_we with cfg_idx / cfg_wdata writes one register per
// cycle (gains, targets, span, floor); write it only while the block is idle.
// Path: a request accepted on req passes the input register, integral stage,
// product stage and output register before its result shows on rsp.
// Throughput: one request per cycle while rsp does not stall; the integral loop
// closes in the single add-and-saturate of the integral stage.
// When rsp stalls, each stage holds its beat and the stages behind it keep
// filling, so req stays ready until all four stages hold a beat.
// Reset: integrals cleared, pipeline emptied, registers at defaults.
// Depends on dpsc_pkg, dpsc_in_if, dpsc_out_if, dpsc_cfg_regs, dpsc_pi_side, dual_pi_speed_controller_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_pi_speed_controller_defines.svh"

module dual_pi_speed_controller
	import dpsc_pkg::*;
#(
	parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	dpsc_in_if.sink                    req,
	dpsc_out_if.source                 rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t                    cfg;
	pipe_ctrl_t              ctrl;
	logic                    v_s1, v_s2, v_s3, out_valid_q;
	logic                    en1, en2, en3, en_out;
	cmd_t                    cmd_s1;
	logic signed [RPM_W-1:0] rpm_left_s1, rpm_right_s1;
	logic [15:0]             target_s1;
	logic [PWM_W-1:0]        pwm_left, pwm_right;
	logic [PWM_W-1:0]        pwm_left_q, pwm_right_q;

	dpsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// elastic pipeline: a stage loads when it is empty or its beat moves on
	assign en_out = !out_valid_q || rsp.ready;
	assign en3    = !v_s3 || en_out;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign req.ready = en1;

	always_comb begin
		ctrl.ld_s2     = en2 && v_s1;
		ctrl.upd_integ = en2 && v_s1 && (cmd_s1 != CMD_IGNORE);
		ctrl.ld_s3     = en3 && v_s2;
	end

	// valid bits, ignored requests drop out after the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= req.valid;
			if (en2)
				v_s2 <= v_s1 && (cmd_s1 != CMD_IGNORE);
			if (en3)
				v_s3 <= v_s2;
			if (en_out)
				out_valid_q <= v_s3;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (en1 && req.valid) begin
			cmd_s1       <= req.cmd;
			rpm_left_s1  <= req.rpm_left;
			rpm_right_s1 <= req.rpm_right;
		end
	end

	// target speed for the request
	always_comb begin
		case (cmd_s1)
			CMD_SLOW: target_s1 = cfg.target_slow;
			CMD_FAST: target_s1 = cfg.target_fast;
			default:  target_s1 = '0;
		endcase
	end

	dpsc_pi_side #(.INTEGRAL_BITS(INTEGRAL_BITS)) u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg),
		.target_s1 (target_s1),
		.rpm_s1    (rpm_left_s1),
		.pwm       (pwm_left)
	);

	dpsc_pi_side #(.INTEGRAL_BITS(INTEGRAL_BITS)) u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg),
		.target_s1 (target_s1),
		.rpm_s1    (rpm_right_s1),
		.pwm       (pwm_right)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			pwm_left_q  <= pwm_left;
			pwm_right_q <= pwm_right;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.pwm_left  = pwm_left_q;
	assign rsp.pwm_right = pwm_right_q;

	// req only backs up when every stage holds a beat
	`DPSC_ASSERT_NOW(a_full_when_blocked, !req.ready, v_s1 && v_s2 && v_s3 && out_valid_q, "req stalled with a free stage")
	// a beat in the product stage is kept while rsp stalls
	`DPSC_ASSERT_NEXT(a_s3_held, v_s3 && out_valid_q && !rsp.ready, v_s3, "product stage lost a beat under stall")
	// an ignored request never reaches the integral stage
	`DPSC_ASSERT_NEXT(a_ignore_dropped, v_s1 && (cmd_s1 == CMD_IGNORE) && en2, !v_s2, "ignored request passed the input stage")

endmodule

`default_nettype wire

/* tb/dpsc_checker.sv */
// checker for the dual pi speed controller: watches the request and result channels
// and the register port, predicts each pwm pair and compares it with the result beats
// depends on dpsc_pkg, dpsc_in_if and dpsc_out_if
`timescale 1ns / 1ps

module dpsc_checker
	import dpsc_pkg::*;
#(
	parameter int INTEGRAL_BITS = INTEGRAL_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	dpsc_in_if                         req,
	dpsc_out_if                        rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                         mismatches,
	output int                         pending
);

	typedef struct packed {
		logic [PWM_W-1:0] left;
		logic [PWM_W-1:0] right;
	} pwm_pair_t;

	localparam longint INTEG_MAX = (64'sd1 <<< (INTEGRAL_BITS - 1)) - 64'sd1;
	localparam longint INTEG_MIN = -INTEG_MAX - 64'sd1;
	localparam longint ITERM_LIM = 64'sd1 <<< 60;
	localparam longint PWM_MAX   = (64'sd1 <<< PWM_W) - 64'sd1;

	cfg_t      shadow;
	longint    integ_left;
	longint    integ_right;
	int        err_count;
	pwm_pair_t pwm_due[$];

	// integral update with saturation at the signed limits
	function automatic longint integrate(input longint integ, input longint err);
		longint acc;
		acc = integ + err;
		if (acc > INTEG_MAX)
			acc = INTEG_MAX;
		else if (acc < INTEG_MIN)
			acc = INTEG_MIN;
		return acc;
	endfunction

	// kp*err + ki*integral in q.20, clamped to 0..span, floor added, byte saturated
	function automatic logic [PWM_W-1:0] pwm_command(input cfg_t c, input longint err,
			input longint acc);
		longint kp, ki, span, base, pterm, iterm, sum, whole, pwm;
		kp    = longint'(c.prop_gain);
		ki    = longint'(c.integ_gain);
		span  = longint'(c.drive_span);
		base  = longint'(c.drive_floor);
		pterm = kp * err * 64'sd256;
		iterm = ki * acc;
		if (iterm > ITERM_LIM)
			iterm = ITERM_LIM;
		else if (iterm < -ITERM_LIM)
			iterm = -ITERM_LIM;
		sum = pterm + iterm;
		if (sum <= 0)
			whole = 0;
		else if (sum >= (span <<< FRAC_SHIFT))
			whole = span;
		else
			whole = sum >>> FRAC_SHIFT;
		pwm = whole + base;
		if (pwm > PWM_MAX)
			pwm = PWM_MAX;
		return pwm[PWM_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pwm_pair_t want;
		longint    tgt;
		longint    err_l;
		longint    err_r;
		if (!arst_n) begin
			shadow.prop_gain   = PROP_GAIN_RST;
			shadow.integ_gain  = INTEG_GAIN_RST;
			shadow.target_slow = TARGET_SLOW_RST;
			shadow.target_fast = TARGET_FAST_RST;
			shadow.drive_span  = DRIVE_SPAN_RST;
			shadow.drive_floor = DRIVE_FLOOR_RST;
			integ_left  = 0;
			integ_right = 0;
			err_count   = 0;
			pwm_due.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			// register writes, issued only while the block is idle
			if (cfg_we) begin
				case (cfg_idx)
					REG_PROP_GAIN:   shadow.prop_gain   = cfg_wdata;
					REG_INTEG_GAIN:  shadow.integ_gain  = cfg_wdata;
					REG_TARGET_SLOW: shadow.target_slow = cfg_wdata;
					REG_TARGET_FAST: shadow.target_fast = cfg_wdata;
					REG_DRIVE_SPAN:  shadow.drive_span  = cfg_wdata[PWM_W-1:0];
					REG_DRIVE_FLOOR: shadow.drive_floor = cfg_wdata[PWM_W-1:0];
					default: ;
				endcase
			end

			// result beat against the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (pwm_due.size() == 0) begin
					$display("t=%0t unexpected result beat: pwm_left %0d pwm_right %0d",
						$time, rsp.pwm_left, rsp.pwm_right);
					err_count++;
				end else begin
					want = pwm_due.pop_front();
					if (rsp.pwm_left !== want.left) begin
						$display("t=%0t pwm_left mismatch: expected %0d actual %0d",
							$time, want.left, rsp.pwm_left);
						err_count++;
					end
					if (rsp.pwm_right !== want.right) begin
						$display("t=%0t pwm_right mismatch: expected %0d actual %0d",
							$time, want.right, rsp.pwm_right);
						err_count++;
					end
				end
			end

			// request beat: advance both integrals and predict the pwm pair
			if (req.valid && req.ready && req.cmd != CMD_IGNORE) begin
				case (req.cmd)
					CMD_SLOW: tgt = longint'(shadow.target_slow);
					CMD_FAST: tgt = longint'(shadow.target_fast);
					default:  tgt = 0;
				endcase
				err_l       = tgt - longint'(req.rpm_left);
				err_r       = tgt - longint'(req.rpm_right);
				integ_left  = integrate(integ_left, err_l);
				integ_right = integrate(integ_right, err_r);
				want.left   = pwm_command(shadow, err_l, integ_left);
				want.right  = pwm_command(shadow, err_r, integ_right);
				pwm_due.push_back(want);
			end

			mismatches <= err_count;
			pending    <= pwm_due.size();
		end
	end

endmodule

/* tb/tb_dual_pi_speed_controller.sv */
// testbench top for the dual pi speed controller: clock, reset, request stimulus,
// result back-pressure, register writes and the verdict
// depends on dpsc_pkg, dpsc_in_if, dpsc_out_if, dpsc_checker and the block itself
`timescale 1ns / 1ps

module tb_dual_pi_speed_controller;
	import dpsc_pkg::*;

	localparam int RESET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 60000;
	localparam int NUM_BLOCKS   = 7;
	localparam int BLOCK_ITEMS  = 250;
	localparam int SOAK_ITEMS   = 40;
	localparam int RPM_NOISE    = 200;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [RPM_W-1:0]     RPM_MAX     = 17'h0FFFF;
	localparam logic [RPM_W-1:0]     RPM_MIN     = 17'h10000;
	localparam logic [RPM_W-1:0]     RPM_ZERO    = 17'h00000;
	localparam logic [RPM_W-1:0]     RPM_ONES    = 17'h1FFFF;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    pending;
	int                    send_idle_pct;
	int                    recv_stall_pct;
	int                    beats_sent;
	int                    ignored_sent;
	int                    reg_writes;
	int                    settings;
	int unsigned           cycles = 0;
	logic [15:0]           cur_slow;
	logic [15:0]           cur_fast;

	dpsc_in_if  req_ch ();
	dpsc_out_if rsp_ch ();

	dual_pi_speed_controller u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	dpsc_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result back-pressure
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// one request beat, with random idle cycles ahead of it
	task automatic send_item(input cmd_t c, input logic [RPM_W-1:0] l,
			input logic [RPM_W-1:0] r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= c;
		req_ch.rpm_left  <= l;
		req_ch.rpm_right <= r;
		do @(posedge clk); while (!req_ch.ready);
		beats_sent++;
		if (c == CMD_IGNORE)
			ignored_sent++;
	endtask

	// stop sending until every result is in, then let the pipeline drain
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all six registers, optionally followed by the two unused indexes
	task automatic apply_config(input logic [15:0] kp, ki, slow, fast,
			input logic [7:0] span, base, input bit spare);
		logic [CFG_IDX_W-1:0] idx [8];
		logic [15:0]          val [8];
		int                   n;
		idx = '{REG_PROP_GAIN, REG_INTEG_GAIN, REG_TARGET_SLOW, REG_TARGET_FAST,
			REG_DRIVE_SPAN, REG_DRIVE_FLOOR, REG_SPARE_6, REG_SPARE_7};
		// upper data bits of the byte registers carry junk that must be dropped
		val = '{kp, ki, slow, fast, {8'($urandom), span}, {8'($urandom), base},
			16'($urandom), 16'($urandom)};
		n = spare ? 8 : 6;
		for (int k = 0; k < n; k++) begin
			cfg_we    <= 1'b1;
			cfg_idx   <= idx[k];
			cfg_wdata <= val[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_slow = slow;
		cur_fast = fast;
		reg_writes += n;
		settings++;
	endtask

	// measured speed a little off the target
	function automatic logic [RPM_W-1:0] near_target(input logic [15:0] tgt);
		return RPM_W'({1'b0, tgt}) + RPM_W'($urandom_range(0, 2 * RPM_NOISE))
			- RPM_W'(RPM_NOISE);
	endfunction

	// mostly speeds close to the target, some full-range noise and ignored requests
	task automatic random_item();
		int          pick;
		cmd_t        c;
		logic [15:0] tgt;
		pick = $urandom_range(0, 99);
		c    = cmd_t'($urandom_range(0, 2));
		tgt  = (c == CMD_SLOW) ? cur_slow : (c == CMD_FAST) ? cur_fast : 16'd0;
		if (pick < 8)
			send_item(CMD_IGNORE, RPM_W'($urandom), RPM_W'($urandom));
		else if (pick < 20)
			send_item(c, RPM_W'($urandom), RPM_W'($urandom));
		else
			send_item(c, near_target(tgt), near_target(tgt));
	endtask

	initial begin
		req_ch.valid     <= 1'b0;
		req_ch.cmd       <= CMD_STOP;
		req_ch.rpm_left  <= RPM_ZERO;
		req_ch.rpm_right <= RPM_ZERO;
		cfg_we           <= 1'b0;
		cfg_idx          <= REG_PROP_GAIN;
		cfg_wdata        <= '0;
		arst_n           <= 1'b0;
		send_idle_pct    <= 7;
		recv_stall_pct   <= 49;
		beats_sent   = 0;
		ignored_sent = 0;
		reg_writes   = 0;
		settings     = 0;
		cur_slow     = TARGET_SLOW_RST;
		cur_fast     = TARGET_FAST_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, field extremes, ignored requests in between
		send_item(CMD_STOP, RPM_ZERO, RPM_ZERO);
		send_item(CMD_SLOW, RPM_ZERO, 17'd480);
		send_item(CMD_FAST, RPM_MAX, RPM_MIN);
		send_item(CMD_IGNORE, RPM_MIN, RPM_MAX);
		send_item(CMD_IGNORE, RPM_ZERO, RPM_ONES);
		send_item(CMD_FAST, RPM_ONES, 17'd1);
		send_item(CMD_SLOW, 17'd480, 17'd480);
		send_item(CMD_STOP, RPM_MAX, RPM_MIN);
		// floor plus span past a byte, unused indexes written too
		quiesce();
		apply_config(PROP_GAIN_RST, INTEG_GAIN_RST, TARGET_SLOW_RST, TARGET_FAST_RST,
			8'd255, 8'd255, 1'b1);
		send_item(CMD_FAST, RPM_MIN, RPM_MIN);
		send_item(CMD_STOP, RPM_ZERO, RPM_ZERO);
		send_item(CMD_IGNORE, RPM_MAX, RPM_MAX);
		send_item(CMD_SLOW, RPM_ZERO, RPM_ZERO);
		// largest gains and targets
		quiesce();
		apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd0, 1'b0);
		send_item(CMD_FAST, RPM_MIN, RPM_MAX);
		send_item(CMD_FAST, RPM_MAX, RPM_MIN);
		send_item(CMD_STOP, RPM_ZERO, RPM_ZERO);
		send_item(CMD_SLOW, RPM_MAX, RPM_ONES);
		// everything zero
		quiesce();
		apply_config(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b1);
		send_item(CMD_FAST, RPM_MIN, RPM_MAX);
		send_item(CMD_STOP, RPM_ZERO, RPM_ZERO);
		send_item(CMD_IGNORE, RPM_ZERO, RPM_ZERO);
		send_item(CMD_SLOW, RPM_MAX, RPM_MIN);

		// random blocks, each under its own register setting
		for (int b = 0; b < NUM_BLOCKS; b++) begin
			quiesce();
			if (b == 3) begin
				send_idle_pct  <= 49;
				recv_stall_pct <= 7;
			end else if (b == 5) begin
				send_idle_pct  <= 0;
				recv_stall_pct <= 0;
			end
			case (b)
				0: apply_config(PROP_GAIN_RST, INTEG_GAIN_RST, TARGET_SLOW_RST,
					TARGET_FAST_RST, DRIVE_SPAN_RST, DRIVE_FLOOR_RST, 1'b0);
				1: apply_config(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 1'b1);
				2: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255,
					1'b0);
				4: apply_config(16'($urandom), 16'($urandom_range(0, 64)),
					16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 1'b0);
				6: apply_config(PROP_GAIN_RST, INTEG_GAIN_RST, 16'($urandom),
					16'($urandom), 8'd255, 8'd0, 1'b1);
				default: apply_config(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 8'($urandom), 8'($urandom), 1'b0);
			endcase
			for (int i = 0; i < BLOCK_ITEMS; i++) begin
				// hold off mid-block until the pipeline is empty
				if (b == 3 && i == BLOCK_ITEMS / 2)
					quiesce();
				random_item();
			end
		end

		// swing both integrals far negative with full-scale errors, then far positive
		quiesce();
		apply_config(16'd127, 16'd1, 16'd0, 16'hFFFF, 8'd255, 8'd0, 1'b0);
		for (int i = 0; i < SOAK_ITEMS; i++)
			send_item(CMD_STOP, RPM_MAX, RPM_MAX - RPM_W'($urandom_range(0, 15)));
		for (int i = 0; i < SOAK_ITEMS; i++)
			send_item(CMD_FAST, RPM_MIN, RPM_MIN + RPM_W'($urandom_range(0, 15)));
		// step back down from the large positive integral
		for (int i = 0; i < 24; i++) begin
			if (i == 12)
				send_item(CMD_IGNORE, RPM_MIN, RPM_MIN);
			send_item(CMD_STOP, RPM_MAX, RPM_MAX);
		end

		quiesce();
		$display("run covered %0d request beats (%0d ignored), %0d register writes in %0d settings",
			beats_sent, ignored_sent, reg_writes, settings);
		$display("three idling patterns, wide integral swings both ways, %0d cycles", cycles);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
